// ===== rtl/fhp_pkg.sv =====
// Fragment header parser package: word types, phase and result codes.
// No dependencies; used by fhp_core and fragment_header_parser.
`timescale 1ns / 1ps

package fhp_pkg;

    localparam logic [7:0] SEP_CHAR  = 8'h3A;   // ':'
    localparam logic [7:0] ZERO_CHAR = 8'h30;   // '0'
    localparam logic [7:0] NINE_CHAR = 8'h39;   // '9'

    typedef enum logic [2:0] {
        PH_TOTAL   = 3'd0,
        PH_NUMBER  = 3'd1,
        PH_SIZE    = 3'd2,
        PH_NAME    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NAME    = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_PAYLOAD = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  byte_value;
        logic [31:0] total_fragments;
        logic [31:0] fragment_number;
        logic [31:0] payload_size;
        logic        size_error;
        logic        packet_last;
    } out_word_t;

endpackage

// ===== rtl/fhp_stream_if.sv =====
// Valid/ready stream channel carrying one word of type word_t.
// Used with fhp_pkg word types.
`timescale 1ns / 1ps

interface fhp_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/fhp_digit_acc.sv =====
// Saturating decimal accumulate: acc * 10 + digit, clamped to 32 bits.
// Depends on nothing beyond plain logic.
`timescale 1ns / 1ps

module fhp_digit_acc (
    input  logic [31:0] acc,
    input  logic [3:0]  digit,
    output logic [31:0] sum
);
    logic [35:0] wide;

    assign wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, digit};
    assign sum  = (wide[35:32] != 4'd0) ? 32'hFFFF_FFFF : wide[31:0];
endmodule

// ===== rtl/fhp_core.sv =====
// Parser state and per-byte decode; result is combinational from the current word.
// Depends on fhp_pkg and fhp_digit_acc.
`timescale 1ns / 1ps

module fhp_core #(
    parameter int MAX_PAYLOAD = 1024,
    parameter int REM_W       = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  fhp_pkg::in_word_t  word,
    output logic               res_valid,
    output fhp_pkg::out_word_t res
);
    fhp_pkg::phase_t phase_reg, phase_next, phase_cur;
    logic [31:0]      total_reg, total_next, total_cur;
    logic [31:0]      number_reg, number_next, number_cur;
    logic [31:0]      size_reg, size_next, size_cur;
    logic             ended_reg, ended_next, ended_cur;
    logic [REM_W-1:0] rem_reg, rem_next, rem_cur, rem_dec;
    logic [31:0]      acc_sel, acc_sum, sz_clamped;
    logic             is_sep, is_digit, too_big;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= fhp_pkg::PH_TOTAL;
            total_reg  <= '0;
            number_reg <= '0;
            size_reg   <= '0;
            ended_reg  <= 1'b0;
            rem_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            total_reg  <= total_next;
            number_reg <= number_next;
            size_reg   <= size_next;
            ended_reg  <= ended_next;
            rem_reg    <= rem_next;
        end
    end

    // start flag drops the packet in progress
    assign phase_cur  = word.packet_start ? fhp_pkg::PH_TOTAL : phase_reg;
    assign total_cur  = word.packet_start ? 32'd0 : total_reg;
    assign number_cur = word.packet_start ? 32'd0 : number_reg;
    assign size_cur   = word.packet_start ? 32'd0 : size_reg;
    assign ended_cur  = word.packet_start ? 1'b0 : ended_reg;
    assign rem_cur    = word.packet_start ? '0 : rem_reg;

    assign is_sep   = (word.data_byte == fhp_pkg::SEP_CHAR);
    assign is_digit = (word.data_byte >= fhp_pkg::ZERO_CHAR) &&
                      (word.data_byte <= fhp_pkg::NINE_CHAR);

    always_comb
    begin
        case (phase_cur)
            fhp_pkg::PH_TOTAL:  acc_sel = total_cur;
            fhp_pkg::PH_NUMBER: acc_sel = number_cur;
            default:            acc_sel = size_cur;
        endcase
    end

    fhp_digit_acc u_acc (
        .acc   (acc_sel),
        .digit (word.data_byte[3:0]),
        .sum   (acc_sum)
    );

    assign too_big    = (size_cur > 32'(MAX_PAYLOAD));
    assign sz_clamped = too_big ? 32'(MAX_PAYLOAD) : size_cur;
    assign rem_dec    = (rem_cur != '0) ? rem_cur - REM_W'(1) : rem_cur;

    always_comb
    begin
        phase_next  = phase_cur;
        total_next  = total_cur;
        number_next = number_cur;
        size_next   = size_cur;
        ended_next  = ended_cur;
        rem_next    = rem_cur;
        res_valid   = 1'b0;
        res         = '0;

        case (phase_cur)
            fhp_pkg::PH_TOTAL, fhp_pkg::PH_NUMBER, fhp_pkg::PH_SIZE:
            begin
                if (is_sep)
                begin
                    ended_next = 1'b0;
                    case (phase_cur)
                        fhp_pkg::PH_TOTAL:  phase_next = fhp_pkg::PH_NUMBER;
                        fhp_pkg::PH_NUMBER: phase_next = fhp_pkg::PH_SIZE;
                        default:            phase_next = fhp_pkg::PH_NAME;
                    endcase
                end
                else if (!ended_cur && is_digit)
                begin
                    case (phase_cur)
                        fhp_pkg::PH_TOTAL:  total_next  = acc_sum;
                        fhp_pkg::PH_NUMBER: number_next = acc_sum;
                        default:            size_next   = acc_sum;
                    endcase
                end
                else
                begin
                    ended_next = 1'b1;
                end
            end
            fhp_pkg::PH_NAME:
            begin
                res_valid = 1'b1;
                if (!is_sep)
                begin
                    res.result_kind = fhp_pkg::KIND_NAME;
                    res.byte_value  = word.data_byte;
                end
                else
                begin
                    res.result_kind     = fhp_pkg::KIND_HEADER;
                    res.total_fragments = total_cur;
                    res.fragment_number = number_cur;
                    res.payload_size    = sz_clamped;
                    res.size_error      = too_big;
                    res.packet_last     = (sz_clamped == 32'd0);
                    rem_next            = sz_clamped[REM_W-1:0];
                    phase_next          = (sz_clamped == 32'd0) ? fhp_pkg::PH_DONE
                                                                : fhp_pkg::PH_PAYLOAD;
                end
            end
            fhp_pkg::PH_PAYLOAD:
            begin
                res_valid        = 1'b1;
                res.result_kind  = fhp_pkg::KIND_PAYLOAD;
                res.byte_value   = word.data_byte;
                res.packet_last  = (rem_dec == '0);
                rem_next         = rem_dec;
                if (rem_dec == '0)
                begin
                    phase_next = fhp_pkg::PH_DONE;
                end
            end
            default:
            begin
                // done, or an unused code: ignore bytes until a start flag
            end
        endcase
    end
endmodule

// ===== rtl/fragment_header_parser.sv =====
// Fragment header parser: total:number:size:name:payload byte stream to results.
// Each accepted word is held in the input register and decoded by fhp_core; its result
// word is then registered in the result register, from which it can be taken.
// Throughput: one byte per cycle; a byte that makes a result waits in the input register
// while the result register holds a word not yet taken, and then the input stalls.
// Reset (rst_n, async low) empties both registers and returns to the total field.
// Depends on fhp_pkg, fhp_stream_if and fhp_core.
`timescale 1ns / 1ps

module fragment_header_parser #(
    parameter int MAX_PAYLOAD = 1024
) (
    input logic          clk,
    input logic          rst_n,
    fhp_stream_if.sink   stream,
    fhp_stream_if.source result
);
    logic               in_valid_reg;
    fhp_pkg::in_word_t  in_word_reg;
    logic               out_valid_reg;
    fhp_pkg::out_word_t out_word_reg;
    logic               core_valid;
    fhp_pkg::out_word_t core_res;
    logic               advance;

    // a stored word moves on unless it makes a result that has nowhere to go
    assign advance = in_valid_reg && (!core_valid || !out_valid_reg || result.ready);
    assign stream.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.valid && stream.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_word_reg <= stream.payload;
        end
    end

    fhp_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .word      (in_word_reg),
        .res_valid (core_valid),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && core_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_valid)
        begin
            out_word_reg <= core_res;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_word_reg;
endmodule
